/* hdl/lsvr_pkg.sv */
package lsvr_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VALUE_W = 32;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int OUT_CNT_W = 5;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // read address select
  localparam logic [1:0] RD_TOP = 2'd0;
  localparam logic [1:0] RD_PTR_DN = 2'd1;
  localparam logic [1:0] RD_PTR_UP1 = 2'd2;
  localparam logic [1:0] RD_PTR_UP2 = 2'd3;

  typedef struct packed {
    logic       latch;
    logic       push;
    logic [1:0] rd_sel;
    logic       ptr_load;
    logic       ptr_dec;
    logic       ptr_inc;
    logic       wr_shift;
    logic       dec_count;
    logic       take_pop;
    logic       set_st;
    logic [1:0] st;
    logic       load_out;
  } lsvr_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       empty;
    logic       match;
    logic       ptr_zero;
    logic       above_hit;
    logic       more_shift;
  } lsvr_stat_t;

endpackage

/* hdl/lsvr_ram.sv */
module lsvr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/lsvr_dpath.sv */
module lsvr_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  lsvr_pkg::lsvr_cmd_t                 ctl,
  output lsvr_pkg::lsvr_stat_t                stat,
  input  logic [1:0]                          command,
  input  logic signed [lsvr_pkg::VALUE_W-1:0] operand_value,
  output logic signed [lsvr_pkg::VALUE_W-1:0] result_value,
  output logic [1:0]                          status,
  output logic [lsvr_pkg::OUT_CNT_W-1:0]      entry_count,
  output logic                                is_empty
);

  import lsvr_pkg::*;

  logic [1:0]         cmd_q;
  logic [VALUE_W-1:0] opnd;
  logic [VALUE_W-1:0] res;
  logic [1:0]         st;
  logic [CW-1:0]      count;
  logic [AW-1:0]      ptr;

  logic [CW-1:0]      cnt_m1;
  logic [CW:0]        ptr_p1;
  logic [CW:0]        ptr_p2;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [VALUE_W-1:0] rdata;
  logic               we;

  assign cnt_m1 = count - CW'(1);
  assign ptr_p1 = (CW + 1)'(ptr) + (CW + 1)'(1);
  assign ptr_p2 = (CW + 1)'(ptr) + (CW + 1)'(2);

  always_comb begin
    case (ctl.rd_sel)
      RD_TOP:     raddr = cnt_m1[AW-1:0];
      RD_PTR_DN:  raddr = ptr - AW'(1);
      RD_PTR_UP1: raddr = ptr_p1[AW-1:0];
      RD_PTR_UP2: raddr = ptr_p2[AW-1:0];
      default:    raddr = cnt_m1[AW-1:0];
    endcase
  end

  assign we = ctl.push | ctl.wr_shift;
  assign waddr = ctl.wr_shift ? ptr : count[AW-1:0];
  assign wdata = ctl.wr_shift ? rdata : opnd;

  lsvr_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + CW'(1);
    end else if (ctl.dec_count) begin
      count <= cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q <= command;
      opnd <= operand_value;
      res <= '0;
      st <= ST_OK;
    end else begin
      if (ctl.take_pop) begin
        res <= rdata;
      end
      if (ctl.set_st) begin
        st <= ctl.st;
      end
    end
    if (ctl.ptr_load) begin
      ptr <= cnt_m1[AW-1:0];
    end else if (ctl.ptr_dec) begin
      ptr <= ptr - AW'(1);
    end else if (ctl.ptr_inc) begin
      ptr <= ptr_p1[AW-1:0];
    end
    if (ctl.load_out) begin
      result_value <= res;
      status <= st;
      entry_count <= OUT_CNT_W'(count);
      is_empty <= (count == '0);
    end
  end

  assign stat.cmd = cmd_q;
  assign stat.full = (count == CW'(STACK_DEPTH));
  assign stat.empty = (count == '0);
  assign stat.match = (rdata == opnd);
  assign stat.ptr_zero = (ptr == '0);
  assign stat.above_hit = (ptr_p1 < (CW + 1)'(count));
  assign stat.more_shift = (ptr_p2 < (CW + 1)'(count));

endmodule

/* hdl/lsvr_ctrl.sv */
module lsvr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  lsvr_pkg::lsvr_stat_t stat,
  output lsvr_pkg::lsvr_cmd_t  ctl
);

  import lsvr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_POP_WAIT = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    ctl = '0;
    ctl.rd_sel = RD_TOP;
    ctl.st = ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (stat.cmd)
          CMD_PUSH: begin
            if (stat.full) begin
              ctl.set_st = 1'b1;
              ctl.st = ST_FULL;
            end else begin
              ctl.push = 1'b1;
            end
          end
          CMD_POP: begin
            if (stat.empty) begin
              ctl.set_st = 1'b1;
              ctl.st = ST_EMPTY;
            end else begin
              // top is read with the old count, then the count drops
              ctl.dec_count = 1'b1;
              state_next = S_POP_WAIT;
            end
          end
          CMD_REMOVE: begin
            if (stat.empty) begin
              ctl.set_st = 1'b1;
              ctl.st = ST_NOTFOUND;
            end else begin
              ctl.ptr_load = 1'b1;
              state_next = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_POP_WAIT: begin
        ctl.take_pop = 1'b1;
        state_next = S_DONE;
      end
      S_SCAN: begin
        // read data holds the entry at ptr
        if (stat.match) begin
          if (stat.above_hit) begin
            ctl.rd_sel = RD_PTR_UP1;
            state_next = S_SHIFT;
          end else begin
            ctl.dec_count = 1'b1;
            state_next = S_DONE;
          end
        end else if (stat.ptr_zero) begin
          ctl.set_st = 1'b1;
          ctl.st = ST_NOTFOUND;
          state_next = S_DONE;
        end else begin
          ctl.rd_sel = RD_PTR_DN;
          ctl.ptr_dec = 1'b1;
        end
      end
      S_SHIFT: begin
        // move entry ptr+1 down into ptr, fetch the next one up
        ctl.wr_shift = 1'b1;
        ctl.rd_sel = RD_PTR_UP2;
        ctl.ptr_inc = 1'b1;
        if (!stat.more_shift) begin
          ctl.dec_count = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/lifo_stack_with_value_removal_core.sv */
// Bounded LIFO of signed 32-bit values with push, pop and remove-by-value.
// Input channel (in_valid/in_stall) carries command and operand_value; the
// output channel (out_valid/out_stall) returns one item per command with
// result_value, status, entry_count and is_empty after the command.
// Entries live in a single-port-read, single-port-write RAM, so every
// command is walked by a small sequencer, one item at a time.
// Steps from input accept to output valid: push, no-op or a full/empty
// error goes through accept, execute and done; pop adds a wait for the
// RAM read; remove adds a scan of entries from the top down to the match
// and a shift of the entries above the match down one slot.
// The next item is taken the cycle after the output register is loaded;
// the RAM walk, one entry per cycle, sets the remove time.
// A result waiting on out_stall does not block the next item: it is taken
// and worked on, and only its own result waits until the register frees.
// Reset empties the stack (count zero) and drops any pending output item;
// RAM contents are not cleared, and only entries below the count are used.
module lifo_stack_with_value_removal_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          command,
  input  logic signed [lsvr_pkg::VALUE_W-1:0] operand_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lsvr_pkg::VALUE_W-1:0] result_value,
  output logic [1:0]                          status,
  output logic [lsvr_pkg::OUT_CNT_W-1:0]      entry_count,
  output logic                                is_empty
);

  import lsvr_pkg::*;

  lsvr_cmd_t  ctl;
  lsvr_stat_t stat;

  lsvr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  lsvr_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .command      (command),
    .operand_value(operand_value),
    .result_value (result_value),
    .status       (status),
    .entry_count  (entry_count),
    .is_empty     (is_empty)
  );

  // one item in flight: an accepted item blocks the input next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is still in work");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |->
      (entry_count == OUT_CNT_W'(STACK_DEPTH) && !is_empty))
    else $error("full reported with a count other than the depth");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (is_empty && result_value == '0))
    else $error("empty reported on a stack that holds entries");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (result_value == '0))
    else $error("nonzero value on a failed command");

endmodule
